@@ src/clt_pkg.sv @@
`default_nettype none

package clt_pkg;

   // Character codes
   localparam logic [7:0] QUOTE_CH = 8'h22;
   localparam logic [7:0] LT_CH    = 8'h3C;
   localparam logic [7:0] GT_CH    = 8'h3E;
   localparam logic [7:0] SPACE_CH = 8'h20;
   localparam logic [7:0] TAB_CH   = 8'h09;
   localparam logic [7:0] CR_CH    = 8'h0D;
   localparam logic [7:0] NUL_CH   = 8'h00;

   // Token roles
   localparam logic [1:0] ROLE_ARG = 2'd0;
   localparam logic [1:0] ROLE_IN  = 2'd1;
   localparam logic [1:0] ROLE_OUT = 2'd2;

   // Pending redirection codes
   localparam logic [1:0] REDIR_NONE   = 2'd0;
   localparam logic [1:0] REDIR_IN     = 2'd1;
   localparam logic [1:0] REDIR_OUT    = 2'd2;
   localparam logic [1:0] REDIR_APPEND = 2'd3;

   // Results one character can cause
   localparam int unsigned MAX_RES = 4;

   typedef struct packed {
      logic [7:0] byte_value;
      logic       has_byte;
      logic [1:0] role;
      logic       token_first;
      logic       token_last;
      logic       append_mode;
      logic       end_of_command;
      logic       error;
   } rsp_item_type;

   typedef struct packed {
      rsp_item_type [MAX_RES-1:0] items;
      logic [2:0]                 count;
   } bundle_type;

   function automatic logic is_space(input logic [7:0] c);
      return (c == SPACE_CH) || ((c >= TAB_CH) && (c <= CR_CH));
   endfunction

   // Append one result; a full bundle drops it
   function automatic bundle_type bundle_push(input bundle_type b, input rsp_item_type it);
      bundle_type r;
      r = b;
      if (b.count != 3'(MAX_RES)) begin
         r.items[b.count[1:0]] = it;
         r.count = b.count + 3'd1;
      end
      return r;
   endfunction

   function automatic rsp_item_type byte_item(input logic [7:0] b, input logic [1:0] role,
                                              input logic first, input logic app);
      rsp_item_type it;
      it = '0;
      it.byte_value  = b;
      it.has_byte    = 1'b1;
      it.role        = role;
      it.token_first = first;
      it.append_mode = app;
      return it;
   endfunction

endpackage

`default_nettype wire

@@ src/command_line_tokenizer.sv @@
`default_nettype none

// Command line tokenizer: takes one character per req_ handshake (zero ends the
// line) and emits one result per rsp_ handshake: token bytes with their role,
// first/last marks, file names after <, > and >>, and an end-of-command result.
// A character is accepted every cycle while the two-entry bundle queue between
// the classifying front end and the output stage has room; the output stage
// gives one result per cycle while rsp_ready takes them, so a character that
// causes several results (up to four) keeps the output busy while they drain,
// and the input stalls once the queue fills. A result passes through the queue entry and the output register.
module command_line_tokenizer
   import clt_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_ch,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_byte_value,
   output logic            rsp_has_byte,
   output logic [1:0]      rsp_role,
   output logic            rsp_token_first,
   output logic            rsp_token_last,
   output logic            rsp_append_mode,
   output logic            rsp_end_of_command,
   output logic            rsp_error
);

   logic         push_valid, push_ready;
   bundle_type   push_bundle;
   logic         head_valid, pop;
   bundle_type   head;
   rsp_item_type rsp_item;

   clt_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_ch      (req_ch),
      .push_valid  (push_valid),
      .push_bundle (push_bundle),
      .push_ready  (push_ready)
   );

   clt_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push_valid  (push_valid),
      .push_bundle (push_bundle),
      .push_ready  (push_ready),
      .pop         (pop),
      .head_valid  (head_valid),
      .head        (head)
   );

   clt_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_item   (rsp_item)
   );

   assign rsp_byte_value     = rsp_item.byte_value;
   assign rsp_has_byte       = rsp_item.has_byte;
   assign rsp_role           = rsp_item.role;
   assign rsp_token_first    = rsp_item.token_first;
   assign rsp_token_last     = rsp_item.token_last;
   assign rsp_append_mode    = rsp_item.append_mode;
   assign rsp_end_of_command = rsp_item.end_of_command;
   assign rsp_error          = rsp_item.error;

endmodule

`default_nettype wire

@@ src/clt_front.sv @@
`default_nettype none

module clt_front
   import clt_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_ch,
   output logic            push_valid,
   output bundle_type      push_bundle,
   input  wire logic       push_ready
);

   logic       in_token_ff, in_token_in;
   logic       quote_ff, quote_in;
   logic       lead_ff, lead_in;
   logic [1:0] pending_ff, pending_in;
   logic [7:0] hold0_ff, hold0_in;
   logic [7:0] hold1_ff, hold1_in;
   logic [1:0] hold_cnt_ff, hold_cnt_in;
   logic       not_op_ff, not_op_in;
   logic [7:0] dly_byte_ff, dly_byte_in;
   logic       dly_valid_ff, dly_valid_in;
   logic [1:0] role_ff, role_in;
   logic       first_ff, first_in;

   bundle_type   bnd;
   rsp_item_type mark;
   logic         accept;
   logic         wrote;
   logic         do_cls, do_feed, do_end, do_eoc;
   logic [7:0]   cls_b;
   logic         app;
   logic [1:0]   last_idx;

   assign accept    = req_valid && push_ready;
   assign req_ready = push_ready;

   // Classify the character and build its result bundle
   always_comb begin
      in_token_in  = in_token_ff;
      quote_in     = quote_ff;
      lead_in      = lead_ff;
      pending_in   = pending_ff;
      hold0_in     = hold0_ff;
      hold1_in     = hold1_ff;
      hold_cnt_in  = hold_cnt_ff;
      not_op_in    = not_op_ff;
      dly_byte_in  = dly_byte_ff;
      dly_valid_in = dly_valid_ff;
      role_in      = role_ff;
      first_in     = first_ff;
      bnd          = '0;
      mark         = '0;
      wrote        = 1'b0;
      do_cls       = 1'b0;
      do_feed      = 1'b0;
      do_end       = 1'b0;
      do_eoc       = 1'b0;
      cls_b        = req_ch;
      app          = 1'b0;
      last_idx     = '0;

      // Decide what the character does
      if (req_ch == NUL_CH) begin
         do_end = in_token_ff;
         do_eoc = 1'b1;
      end else if (!in_token_ff) begin
         if (!is_space(req_ch)) begin
            in_token_in  = 1'b1;
            first_in     = 1'b0;
            hold_cnt_in  = '0;
            not_op_in    = 1'b0;
            dly_valid_in = 1'b0;
            role_in      = (pending_ff == REDIR_NONE) ? ROLE_ARG :
                           (pending_ff == REDIR_IN)   ? ROLE_IN  : ROLE_OUT;
            if (req_ch == QUOTE_CH) begin
               lead_in  = 1'b1;
               quote_in = 1'b1;
            end else begin
               lead_in  = 1'b0;
               quote_in = 1'b0;
               do_cls   = 1'b1;
            end
         end
      end else if (req_ch == QUOTE_CH) begin
         quote_in = ~quote_ff;
         do_feed  = 1'b1;
      end else if (!quote_ff && is_space(req_ch)) begin
         do_end = 1'b1;
      end else begin
         do_feed = 1'b1;
      end

      // Delay one byte in a token that opened with a quote
      if (do_feed) begin
         if (lead_ff) begin
            do_cls       = dly_valid_ff;
            cls_b        = dly_byte_ff;
            dly_byte_in  = req_ch;
            dly_valid_in = 1'b1;
         end else begin
            do_cls = 1'b1;
         end
      end

      // Flush the delayed byte at token end unless it is a closing quote
      if (do_end) begin
         if (dly_valid_ff && (dly_byte_ff != QUOTE_CH)) begin
            do_cls = 1'b1;
            cls_b  = dly_byte_ff;
         end
         dly_valid_in = 1'b0;
      end

      // Hold candidate operator bytes, emit everything else
      app = (role_in == ROLE_OUT) && (pending_in == REDIR_APPEND);
      if (do_cls) begin
         if ((role_in != ROLE_ARG) || not_op_in) begin
            bnd      = bundle_push(bnd, byte_item(cls_b, role_in, !first_in, app));
            first_in = 1'b1;
            wrote    = 1'b1;
         end else if (hold_cnt_in == 2'd0) begin
            if ((cls_b == LT_CH) || (cls_b == GT_CH)) begin
               hold0_in    = cls_b;
               hold_cnt_in = 2'd1;
            end else begin
               not_op_in = 1'b1;
               bnd       = bundle_push(bnd, byte_item(cls_b, role_in, !first_in, app));
               first_in  = 1'b1;
               wrote     = 1'b1;
            end
         end else if ((hold_cnt_in == 2'd1) && (hold0_in == GT_CH) && (cls_b == GT_CH)) begin
            hold1_in    = cls_b;
            hold_cnt_in = 2'd2;
         end else begin
            not_op_in = 1'b1;
            bnd       = bundle_push(bnd, byte_item(hold0_in, role_in, !first_in, app));
            first_in  = 1'b1;
            if (hold_cnt_in == 2'd2) begin
               bnd = bundle_push(bnd, byte_item(hold1_in, role_in, 1'b0, app));
            end
            hold_cnt_in = 2'd0;
            bnd         = bundle_push(bnd, byte_item(cls_b, role_in, 1'b0, app));
            wrote       = 1'b1;
         end
      end

      // Close the token: record a redirection or mark the token's last result
      if (do_end) begin
         if ((role_in == ROLE_ARG) && !not_op_in && (hold_cnt_in != 2'd0)) begin
            if (hold_cnt_in == 2'd2) begin
               pending_in = REDIR_APPEND;
            end else begin
               pending_in = (hold0_in == LT_CH) ? REDIR_IN : REDIR_OUT;
            end
         end else begin
            if (wrote) begin
               last_idx = 2'(bnd.count - 3'd1);
               bnd.items[last_idx].token_last = 1'b1;
            end else begin
               mark.role        = role_in;
               mark.token_first = !first_in;
               mark.token_last  = 1'b1;
               mark.append_mode = app;
               bnd = bundle_push(bnd, mark);
            end
            if (role_in != ROLE_ARG) begin
               pending_in = REDIR_NONE;
            end
         end
         in_token_in = 1'b0;
         quote_in    = 1'b0;
         lead_in     = 1'b0;
         hold_cnt_in = 2'd0;
         not_op_in   = 1'b0;
         first_in    = 1'b0;
         role_in     = ROLE_ARG;
      end

      // End of line: report, then return to the idle state
      if (do_eoc) begin
         mark                = '0;
         mark.end_of_command = 1'b1;
         mark.error          = (pending_in != REDIR_NONE);
         bnd                 = bundle_push(bnd, mark);
         in_token_in         = 1'b0;
         quote_in            = 1'b0;
         lead_in             = 1'b0;
         pending_in          = REDIR_NONE;
         hold_cnt_in         = 2'd0;
         not_op_in           = 1'b0;
         dly_valid_in        = 1'b0;
         role_in             = ROLE_ARG;
         first_in            = 1'b0;
      end
   end

   assign push_valid  = accept && (bnd.count != 3'd0);
   assign push_bundle = bnd;

   // Advance tokenizer state on each accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         in_token_ff  <= 1'b0;
         quote_ff     <= 1'b0;
         lead_ff      <= 1'b0;
         pending_ff   <= REDIR_NONE;
         hold_cnt_ff  <= 2'd0;
         not_op_ff    <= 1'b0;
         dly_valid_ff <= 1'b0;
         role_ff      <= ROLE_ARG;
         first_ff     <= 1'b0;
      end else if (accept) begin
         in_token_ff  <= in_token_in;
         quote_ff     <= quote_in;
         lead_ff      <= lead_in;
         pending_ff   <= pending_in;
         hold_cnt_ff  <= hold_cnt_in;
         not_op_ff    <= not_op_in;
         dly_valid_ff <= dly_valid_in;
         role_ff      <= role_in;
         first_ff     <= first_in;
      end
   end

   // Hold bytes need no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         hold0_ff    <= hold0_in;
         hold1_ff    <= hold1_in;
         dly_byte_ff <= dly_byte_in;
      end
   end

endmodule

`default_nettype wire

@@ src/clt_queue.sv @@
`default_nettype none

module clt_queue
   import clt_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic push_valid,
   input  wire bundle_type push_bundle,
   output logic      push_ready,
   input  wire logic pop,
   output logic      head_valid,
   output bundle_type head
);

   bundle_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_push, do_pop;

   assign push_ready = (cnt_ff != 2'd2);
   assign head_valid = (cnt_ff != 2'd0);
   assign head       = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && head_valid;

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Store the incoming bundle
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_bundle;
      end
   end

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3) else $error("queue fill count out of range");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> push_ready) else $error("push into full queue");

endmodule

`default_nettype wire

@@ src/clt_back.sv @@
`default_nettype none

module clt_back
   import clt_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic head_valid,
   input  wire bundle_type head,
   output logic      pop,
   output logic      rsp_valid,
   input  wire logic rsp_ready,
   output rsp_item_type rsp_item
);

   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_item_ff;
   logic [1:0]   idx_ff, idx_in;
   logic         load;
   logic         last;

   assign load = head_valid && (!rsp_valid_ff || rsp_ready);
   assign last = ((3'(idx_ff) + 3'd1) == head.count);
   assign pop  = load && last;

   // Step through the head bundle one result per cycle while the output is free or taken
   always_comb begin
      idx_in = idx_ff;
      if (load) begin
         idx_in = last ? 2'd0 : idx_ff + 2'd1;
      end
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         idx_ff       <= 2'd0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
      end
   end

   // Hold the output item until taken
   always_ff @(posedge clock) begin
      if (load) begin
         rsp_item_ff <= head.items[idx_ff];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   a_idx_in_bundle: assert property (@(posedge clock) disable iff (reset)
      head_valid |-> (3'(idx_ff) < head.count)) else $error("result index past bundle");

   a_idx_home: assert property (@(posedge clock) disable iff (reset)
      !head_valid |-> (idx_ff == 2'd0)) else $error("result index left over");

endmodule

`default_nettype wire
